// ----- design/cpr_pkg.sv -----
// shared constants and controller/datapath interface types for the clock page replacement block
package cpr_pkg;

   // default sizing, handed to the top level parameters
   localparam int MAX_FRAMES_DEF = 8;
   localparam int PAGE_BITS_DEF  = 16;

   // fixed field widths of the ports
   localparam int CFG_W         = 4;
   localparam int FRAME_INDEX_W = 3;
   localparam int EVICT_W       = 16;

   // ring size after reset
   localparam logic [CFG_W-1:0] FRAMES_RESET = 4'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic start;       // latch the request page and restart the tag search
      logic search_en;   // step the tag search by one frame
      logic hit_take;    // record a hit on the frame under compare
      logic fill_take;   // place the page in the next empty frame
      logic sweep_en;    // one step of the clock hand
      logic evict_take;  // replace the frame under the hand
      logic rsp_load;    // move the finished result into the output register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic match;        // compared tag equals the request page
      logic search_done;  // every resident frame compared without a match
      logic room;         // an empty frame is left inside the ring
      logic found;        // frame under the hand has a clear reference bit
      logic rsp_free;     // output register can take a result this cycle
   } status_type;

endpackage

// ----- design/cpr_ram.sv -----
// generic single write port, single read port RAM with registered read data
module cpr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cpr_ctrl.sv -----
// sequencing state machine: search, fill, hand sweep, eviction and result hand-off
module cpr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cpr_pkg::status_type status,
   output cpr_pkg::cmd_type    cmd
);

   import cpr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_FILL,
      S_SWEEP,
      S_EVICT,
      S_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   // command decode and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search_en = 1'b1;
            if (status.match) begin
               cmd.hit_take = 1'b1;
               state_in     = S_RESP;
            end else if (status.search_done) begin
               state_in = status.room ? S_FILL : S_SWEEP;
            end
         end
         S_FILL: begin
            cmd.fill_take = 1'b1;
            state_in      = S_RESP;
         end
         S_SWEEP: begin
            cmd.sweep_en = 1'b1;
            if (status.found) begin
               state_in = S_EVICT;
            end
         end
         S_EVICT: begin
            cmd.evict_take = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/cpr_datapath.sv -----
// frame tags, reference bits, fill count, clock hand, config register and output register
module cpr_datapath #(
   parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cpr_pkg::cmd_type                  cmd,
   output cpr_pkg::status_type               status,
   input  logic [PAGE_BITS-1:0]              req_page,
   input  logic                              csr_valid,
   input  logic [cpr_pkg::CFG_W-1:0]         csr_frames_in_use,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_fault,
   output logic [cpr_pkg::FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic                              rsp_evict_valid,
   output logic [cpr_pkg::EVICT_W-1:0]       rsp_evicted_page
);

   import cpr_pkg::*;

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // control state
   logic [CFG_W-1:0]      cfg_ff;
   logic [MAX_FRAMES-1:0] ref_ff, ref_in;
   logic [CNT_W-1:0]      filled_ff, filled_in;
   logic [IDX_W-1:0]      hand_ff, hand_in;
   logic [CNT_W-1:0]      search_idx_ff, search_idx_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [PAGE_BITS-1:0]     page_ff, page_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                     res_fault_ff, res_fault_in;
   logic [IDX_W-1:0]         res_slot_ff, res_slot_in;
   logic                     res_evict_ff, res_evict_in;
   logic [PAGE_BITS-1:0]     res_evp_ff, res_evp_in;
   logic                     rsp_fault_ff;
   logic [FRAME_INDEX_W-1:0] rsp_frame_index_ff;
   logic                     rsp_evict_valid_ff;
   logic [EVICT_W-1:0]       rsp_evicted_page_ff;

   // tag memory ports
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [PAGE_BITS-1:0] rd_data;

   // ring geometry
   logic [CMP_W-1:0] cfg_wide;
   logic [CNT_W-1:0] ring_n;
   logic [CNT_W-1:0] valid_cnt;
   logic [IDX_W-1:0] hand_eff;
   logic [CNT_W-1:0] hand_inc;
   logic [IDX_W-1:0] hand_adv;
   logic [CNT_W-1:0] cmp_inc;

   cpr_ram #(
      .WIDTH (PAGE_BITS),
      .DEPTH (MAX_FRAMES)
   ) u_tags (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (page_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ring size saturated to one..MAX_FRAMES, resident frame count inside it
   always_comb begin
      cfg_wide = CMP_W'(cfg_ff);
      if (cfg_wide == '0) begin
         ring_n = CNT_W'(1);
      end else if (cfg_wide > CMP_W'(MAX_FRAMES)) begin
         ring_n = CNT_W'(MAX_FRAMES);
      end else begin
         ring_n = CNT_W'(cfg_wide);
      end
      valid_cnt = (filled_ff < ring_n) ? filled_ff : ring_n;
   end

   // hand wraps to zero when the ring has shrunk below it
   always_comb begin
      hand_eff = (CNT_W'(hand_ff) >= ring_n) ? '0 : hand_ff;
      hand_inc = CNT_W'(hand_eff) + CNT_W'(1);
      hand_adv = (hand_inc == ring_n) ? '0 : IDX_W'(hand_inc);
   end

   // status back to the controller
   always_comb begin
      cmp_inc            = CNT_W'(cmp_idx_ff) + CNT_W'(1);
      status.match       = cmp_valid_ff && (rd_data == page_ff);
      status.search_done = (valid_cnt == '0) ||
                           (cmp_valid_ff && (rd_data != page_ff) && (cmp_inc == valid_cnt));
      status.room        = (filled_ff < ring_n);
      status.found       = !ref_ff[hand_eff];
      status.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   // next state of search, ring and result
   always_comb begin
      page_in       = page_ff;
      ref_in        = ref_ff;
      filled_in     = filled_ff;
      hand_in       = hand_ff;
      search_idx_in = search_idx_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      res_fault_in  = res_fault_ff;
      res_slot_in   = res_slot_ff;
      res_evict_in  = res_evict_ff;
      res_evp_in    = res_evp_ff;
      wr_en         = 1'b0;
      wr_addr       = hand_ff;
      rd_en         = 1'b0;
      rd_addr       = search_idx_ff[IDX_W-1:0];

      // new request
      if (cmd.start) begin
         page_in       = req_page;
         search_idx_in = '0;
         cmp_valid_in  = 1'b0;
      end

      // search: one tag read issued per cycle, compared the cycle after
      if (cmd.search_en) begin
         if (search_idx_ff < valid_cnt) begin
            rd_en         = 1'b1;
            search_idx_in = search_idx_ff + CNT_W'(1);
            cmp_valid_in  = 1'b1;
            cmp_idx_in    = search_idx_ff[IDX_W-1:0];
         end else begin
            cmp_valid_in = 1'b0;
         end
      end

      // hit: give the frame a second chance
      if (cmd.hit_take) begin
         ref_in[cmp_idx_ff] = 1'b1;
         res_fault_in       = 1'b0;
         res_slot_in        = cmp_idx_ff;
         res_evict_in       = 1'b0;
         res_evp_in         = '0;
      end

      // miss with an empty frame left
      if (cmd.fill_take) begin
         wr_en                          = 1'b1;
         wr_addr                        = filled_ff[IDX_W-1:0];
         ref_in[filled_ff[IDX_W-1:0]]   = 1'b1;
         filled_in                      = filled_ff + CNT_W'(1);
         res_fault_in                   = 1'b1;
         res_slot_in                    = filled_ff[IDX_W-1:0];
         res_evict_in                   = 1'b0;
         res_evp_in                     = '0;
      end

      // hand sweep: clear and pass, or stop and fetch the victim tag
      if (cmd.sweep_en) begin
         if (ref_ff[hand_eff]) begin
            ref_in[hand_eff] = 1'b0;
            hand_in          = hand_adv;
         end else begin
            hand_in = hand_eff;
            rd_en   = 1'b1;
            rd_addr = hand_eff;
         end
      end

      // replace the victim and step past it
      if (cmd.evict_take) begin
         wr_en            = 1'b1;
         wr_addr          = hand_ff;
         ref_in[hand_ff]  = 1'b1;
         hand_in          = hand_adv;
         res_fault_in     = 1'b1;
         res_slot_in      = hand_ff;
         res_evict_in     = 1'b1;
         res_evp_in       = rd_data;
      end
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= FRAMES_RESET;
         ref_ff        <= '0;
         filled_ff     <= '0;
         hand_ff       <= '0;
         search_idx_ff <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            cfg_ff <= csr_frames_in_use;
         end
         ref_ff        <= ref_in;
         filled_ff     <= filled_in;
         hand_ff       <= hand_in;
         search_idx_ff <= search_idx_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      cmp_idx_ff   <= cmp_idx_in;
      res_fault_ff <= res_fault_in;
      res_slot_ff  <= res_slot_in;
      res_evict_ff <= res_evict_in;
      res_evp_ff   <= res_evp_in;
      if (cmd.rsp_load) begin
         rsp_fault_ff        <= res_fault_ff;
         rsp_frame_index_ff  <= FRAME_INDEX_W'(res_slot_ff);
         rsp_evict_valid_ff  <= res_evict_ff;
         rsp_evicted_page_ff <= EVICT_W'(res_evp_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fault        = rsp_fault_ff;
   assign rsp_frame_index  = rsp_frame_index_ff;
   assign rsp_evict_valid  = rsp_evict_valid_ff;
   assign rsp_evicted_page = rsp_evicted_page_ff;

`ifndef ASSERT_OFF
   // at most one result-producing command per cycle
   a_one_take: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.hit_take, cmd.fill_take, cmd.evict_take, cmd.rsp_load}))
      else $error("more than one result command in a cycle");

   // fill count never passes the number of frames
   a_filled_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= CNT_W'(MAX_FRAMES))
      else $error("fill count beyond frame count");

   // a fill only happens while an empty frame is inside the ring
   a_fill_room: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_take |-> status.room)
      else $error("fill with no empty frame in the ring");

   // a hit leaves the frame's reference bit set
   a_hit_ref: assert property (@(posedge clock) disable iff (reset)
      cmd.hit_take |=> ref_ff[$past(cmp_idx_ff)])
      else $error("reference bit not set after hit");

   // the victim lies inside the ring and had its bit clear
   a_evict_ring: assert property (@(posedge clock) disable iff (reset)
      cmd.evict_take |-> (CNT_W'(hand_ff) < ring_n) && !ref_ff[hand_ff])
      else $error("victim outside the ring or still referenced");
`endif

endmodule

// ----- design/clock_page_replacement.sv -----
// top level of the clock (second-chance) page replacement block
// Each request carries one page number and yields exactly one response: fault, the frame that
// holds the page afterward, and the evicted page when a resident page was replaced. Requests
// are handled one at a time by a controller and a datapath around a tag RAM with registered
// reads. A miss reads every resident frame (r of them) at one tag read per cycle, then either
// fills the next empty frame or lets the clock hand step one frame per cycle, at most n+1
// steps for a ring of n frames, before the victim read and write. The response sits in an
// output register, so the next request is accepted while it waits. The user must write the
// ring size register through the csr port only while the block is idle; the block does not
// enforce this. The port is always ready; a value of zero acts as one and values above
// MAX_FRAMES act as MAX_FRAMES.
module clock_page_replacement #(
   parameter int MAX_FRAMES = cpr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = cpr_pkg::PAGE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [PAGE_BITS-1:0]              req_page,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_fault,
   output logic [cpr_pkg::FRAME_INDEX_W-1:0] rsp_frame_index,
   output logic                              rsp_evict_valid,
   output logic [cpr_pkg::EVICT_W-1:0]       rsp_evicted_page,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cpr_pkg::CFG_W-1:0]         csr_frames_in_use
);

   import cpr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   // sequencer
   cpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // ring state and result path
   cpr_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_page          (req_page),
      .csr_valid         (csr_valid),
      .csr_frames_in_use (csr_frames_in_use),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fault         (rsp_fault),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evict_valid   (rsp_evict_valid),
      .rsp_evicted_page  (rsp_evicted_page)
   );

endmodule
